### rtl/core/single_wire_sensor_frame_decoder_assert.svh
// Assertion macros used by the sensor frame decoder top level.
`ifndef SINGLE_WIRE_SENSOR_FRAME_DECODER_ASSERT_SVH
`define SINGLE_WIRE_SENSOR_FRAME_DECODER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SWSFD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swsfd assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SWSFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swsfd assertion failed");

`endif

### rtl/core/swsfd_pkg.sv
// Types, codes and sizes shared by the sensor frame decoder modules.
`default_nettype none

package swsfd_pkg;

    localparam int FRAME_EDGES = 41;
    localparam int STORE_DEPTH = 48;
    localparam int DATA_BITS   = 40;

    localparam int EDGE_W     = 6;
    localparam int ADDR_W     = $clog2(STORE_DEPTH);
    localparam int BIT_CNT_W  = $clog2(DATA_BITS);
    localparam int INTERVAL_W = 16;
    localparam int STAMP_W    = 32;
    localparam int TICK_W     = 8;

    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_EDGE  = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_SUM     = 2'd1;
    localparam logic [1:0] STATUS_ZERO    = 2'd2;
    localparam logic [1:0] STATUS_TIMEOUT = 2'd3;

    localparam logic [1:0] CFG_BIT_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_RESPONSE_MIN  = 2'd1;
    localparam logic [1:0] CFG_RESPONSE_MAX  = 2'd2;
    localparam logic [1:0] CFG_TIMEOUT_TICKS = 2'd3;

    localparam logic [INTERVAL_W-1:0] RST_BIT_THRESHOLD = 16'd90;
    localparam logic [INTERVAL_W-1:0] RST_RESPONSE_MIN  = 16'd120;
    localparam logic [INTERVAL_W-1:0] RST_RESPONSE_MAX  = 16'd220;
    localparam logic [TICK_W-1:0]     RST_TIMEOUT_TICKS = 8'd30;

    typedef struct packed {
        logic [1:0]         func;
        logic [STAMP_W-1:0] edge_stamp;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        status;
        logic [7:0]        humidity_whole;
        logic [7:0]        humidity_tenths;
        logic [7:0]        temperature_whole;
        logic [7:0]        temperature_tenths;
        logic [7:0]        sum_byte;
        logic [EDGE_W-1:0] edges_seen;
    } t_out_item;

    typedef struct packed {
        logic [INTERVAL_W-1:0] bit_threshold;
        logic [INTERVAL_W-1:0] response_min;
        logic [INTERVAL_W-1:0] response_max;
        logic [TICK_W-1:0]     timeout_ticks;
    } t_cfg;

    typedef struct packed {
        logic      done;
        t_out_item item;
    } t_dec_result;

endpackage

`default_nettype wire

### rtl/core/single_wire_sensor_frame_decoder.sv
// Top level of the single-wire sensor frame decoder.
// Usage: the input channel carries one transaction per command: start, captured
// edge timestamp or millisecond tick. A start clears the capture and arms it;
// edges store their 16-bit interval in the interval RAM; ticks count toward the
// timeout. Edges and ticks while not armed, and the unused command code, are
// dropped. The output channel carries one transaction per finished frame or
// timeout. Configuration is a plain write port; the user must write it only
// while the block is idle, which the block itself does not enforce. Commands
// that produce no result are taken one per cycle while the block is idle. The
// edge that completes the frame starts a decode that reads the interval RAM
// once per cycle, one read for the response interval and one per data bit; no
// command is taken during the decode. Each result passes from the pending
// register to the output register. A pending result waits in the output
// register while the receiver stalls; the block takes further commands
// meanwhile until it has a second result to hand over. Reset returns the
// configuration registers to their defaults and disarms capture; the RAM needs
// no clearing since reads beyond the captured edge count return zero.
`default_nettype none
`include "single_wire_sensor_frame_decoder_assert.svh"

module single_wire_sensor_frame_decoder (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  swsfd_pkg::t_in_item    i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output swsfd_pkg::t_out_item   o_out_data,
    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_idx,
    input  logic [15:0]            i_cfg_data
);
    import swsfd_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_EMIT
    } t_state;

    t_state                r_state;
    t_cfg                  r_cfg;
    logic                  r_capturing;
    logic [EDGE_W-1:0]     r_edge_cnt;
    logic [INTERVAL_W-1:0] r_last_stamp;
    logic [TICK_W-1:0]     r_tick_cnt;
    t_out_item             r_pend;
    logic                  r_out_valid;
    t_out_item             r_out_data;

    logic                  w_accept;
    logic                  w_edge;
    logic                  w_tick;
    logic                  w_wr_en;
    logic [EDGE_W-1:0]     w_edge_next;
    logic                  w_dec_start;
    logic [INTERVAL_W-1:0] w_interval;
    logic                  w_rd_en;
    logic [ADDR_W-1:0]     w_rd_addr;
    logic [INTERVAL_W-1:0] w_rd_data;
    t_dec_result           w_dec_result;
    logic                  w_out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_edge      = w_accept && r_capturing && (i_in_data.func == FUNC_EDGE);
    assign w_tick      = w_accept && r_capturing && (i_in_data.func == FUNC_TICK);
    assign w_edge_next = r_edge_cnt + 1'b1;
    assign w_wr_en     = w_edge && (int'(r_edge_cnt) < STORE_DEPTH);
    assign w_dec_start = w_edge && (int'(w_edge_next) >= FRAME_EDGES);
    // Only the low half of the stamps matters after truncation.
    assign w_interval  = i_in_data.edge_stamp[INTERVAL_W-1:0] - r_last_stamp;
    assign w_out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bit_threshold <= RST_BIT_THRESHOLD;
            r_cfg.response_min  <= RST_RESPONSE_MIN;
            r_cfg.response_max  <= RST_RESPONSE_MAX;
            r_cfg.timeout_ticks <= RST_TIMEOUT_TICKS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BIT_THRESHOLD: r_cfg.bit_threshold <= i_cfg_data;
                CFG_RESPONSE_MIN:  r_cfg.response_min  <= i_cfg_data;
                CFG_RESPONSE_MAX:  r_cfg.response_max  <= i_cfg_data;
                CFG_TIMEOUT_TICKS: r_cfg.timeout_ticks <= i_cfg_data[TICK_W-1:0];
                default:           r_cfg               <= r_cfg;
            endcase
        end
    end

    swsfd_interval_ram #(
        .DEPTH(STORE_DEPTH),
        .WIDTH(INTERVAL_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_wr_en),
        .i_waddr (r_edge_cnt[ADDR_W-1:0]),
        .i_wdata (w_interval),
        .i_re    (w_rd_en),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rd_data)
    );

    swsfd_bit_decoder u_decoder (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_dec_start),
        .i_fill    (w_edge_next),
        .i_cfg     (r_cfg),
        .o_rd_en   (w_rd_en),
        .o_rd_addr (w_rd_addr),
        .i_rd_data (w_rd_data),
        .o_result  (w_dec_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_capturing  <= 1'b0;
            r_edge_cnt   <= '0;
            r_last_stamp <= '0;
            r_tick_cnt   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept && i_in_data.func == FUNC_START) begin
                        r_capturing  <= 1'b1;
                        r_edge_cnt   <= '0;
                        r_last_stamp <= '0;
                        r_tick_cnt   <= '0;
                    end else if (w_edge) begin
                        r_last_stamp <= i_in_data.edge_stamp[INTERVAL_W-1:0];
                        r_edge_cnt   <= w_edge_next;
                        if (w_dec_start) begin
                            r_capturing <= 1'b0;
                            r_state     <= S_DECODE;
                        end
                    end else if (w_tick) begin
                        if (r_tick_cnt >= r_cfg.timeout_ticks) begin
                            r_capturing               <= 1'b0;
                            r_pend.status             <= STATUS_TIMEOUT;
                            r_pend.humidity_whole     <= '0;
                            r_pend.humidity_tenths    <= '0;
                            r_pend.temperature_whole  <= '0;
                            r_pend.temperature_tenths <= '0;
                            r_pend.sum_byte           <= '0;
                            r_pend.edges_seen         <= r_edge_cnt;
                            r_state                   <= S_EMIT;
                        end else begin
                            r_tick_cnt <= r_tick_cnt + 1'b1;
                        end
                    end
                end
                S_DECODE: begin
                    if (w_dec_result.done) begin
                        r_pend  <= w_dec_result.item;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_data  <= r_pend;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `SWSFD_ASSERT_NOW(a_done_only_in_decode, i_clk, i_rst_n, w_dec_result.done, r_state == S_DECODE)
    `SWSFD_ASSERT_NOW(a_edge_cnt_bounded, i_clk, i_rst_n, 1'b1, int'(r_edge_cnt) <= FRAME_EDGES)
    `SWSFD_ASSERT_NEXT(a_frame_end_decodes, i_clk, i_rst_n, w_dec_start, r_state == S_DECODE && !r_capturing)
    `SWSFD_ASSERT_NOW(a_emit_disarmed, i_clk, i_rst_n, r_state != S_IDLE, !r_capturing)

endmodule

`default_nettype wire

### rtl/core/swsfd_interval_ram.sv
// Single-port-write, single-port-read synchronous RAM for the interval store.
`default_nettype none

module swsfd_interval_ram #(
    parameter int DEPTH = 48,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/core/swsfd_bit_decoder.sv
// Sequencer that walks the stored intervals and builds the five frame bytes.
`default_nettype none

module swsfd_bit_decoder (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [swsfd_pkg::EDGE_W-1:0]     i_fill,
    input  swsfd_pkg::t_cfg                  i_cfg,
    output logic                             o_rd_en,
    output logic [swsfd_pkg::ADDR_W-1:0]     o_rd_addr,
    input  logic [swsfd_pkg::INTERVAL_W-1:0] i_rd_data,
    output swsfd_pkg::t_dec_result           o_result
);
    import swsfd_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_HEAD,
        S_BITS,
        S_DONE
    } t_state;

    t_state                r_state;
    logic [ADDR_W-1:0]     r_addr;
    logic                  r_zero;
    logic [EDGE_W-1:0]     r_fill;
    logic [BIT_CNT_W-1:0]  r_bit_cnt;
    logic [DATA_BITS-1:0]  r_shift;
    logic                  r_done;
    t_out_item             r_item;

    logic [INTERVAL_W-1:0] w_value;
    logic [ADDR_W-1:0]     w_offset;
    logic [ADDR_W-1:0]     w_rd_addr;
    logic [EDGE_W-1:0]     w_fill;
    logic                  w_last_bit;
    logic [7:0]            w_b0;
    logic [7:0]            w_b1;
    logic [7:0]            w_b2;
    logic [7:0]            w_b3;
    logic [7:0]            w_b4;
    logic [7:0]            w_sum;
    logic [1:0]            w_status;

    // Reads at or beyond the fill count are forced to zero, since the RAM is never cleared.
    assign w_value    = r_zero ? '0 : i_rd_data;
    assign w_offset   = (w_value >= i_cfg.response_min && w_value <= i_cfg.response_max)
                        ? ADDR_W'(1) : ADDR_W'(2);
    assign w_last_bit = (r_bit_cnt == BIT_CNT_W'(DATA_BITS - 1));
    assign w_fill     = (r_state == S_IDLE) ? i_fill : r_fill;

    always_comb begin
        unique case (r_state)
            S_HEAD:  w_rd_addr = w_offset;
            S_BITS:  w_rd_addr = r_addr + 1'b1;
            default: w_rd_addr = '0;
        endcase
    end

    assign o_rd_en   = (r_state == S_IDLE && i_start) || (r_state == S_HEAD)
                       || (r_state == S_BITS && !w_last_bit);
    assign o_rd_addr = w_rd_addr;

    assign w_b0  = r_shift[39:32];
    assign w_b1  = r_shift[31:24];
    assign w_b2  = r_shift[23:16];
    assign w_b3  = r_shift[15:8];
    assign w_b4  = r_shift[7:0];
    assign w_sum = w_b0 + w_b1 + w_b2 + w_b3;

    always_comb begin
        priority if (w_sum != w_b4) begin
            w_status = STATUS_SUM;
        end else if (w_b0 == 8'd0 && w_b2 == 8'd0) begin
            w_status = STATUS_ZERO;
        end else begin
            w_status = STATUS_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (o_rd_en) begin
                r_addr <= w_rd_addr;
                r_zero <= (EDGE_W'(w_rd_addr) >= w_fill);
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_fill  <= i_fill;
                        r_state <= S_HEAD;
                    end
                end
                S_HEAD: begin
                    r_bit_cnt <= '0;
                    r_state   <= S_BITS;
                end
                S_BITS: begin
                    r_shift   <= {r_shift[DATA_BITS-2:0], (w_value > i_cfg.bit_threshold)};
                    r_bit_cnt <= r_bit_cnt + 1'b1;
                    if (w_last_bit) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_item.status             <= w_status;
                    r_item.humidity_whole     <= w_b0;
                    r_item.humidity_tenths    <= w_b1;
                    r_item.temperature_whole  <= w_b2;
                    r_item.temperature_tenths <= w_b3;
                    r_item.sum_byte           <= w_b4;
                    r_item.edges_seen         <= r_fill;
                    r_done                    <= 1'b1;
                    r_state                   <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_result.done = r_done;
    assign o_result.item = r_item;

endmodule

`default_nettype wire

### sim/tb_single_wire_sensor_frame_decoder.sv
// Self-checking testbench for the single-wire sensor frame decoder.
`timescale 1ns / 1ps

module tb_single_wire_sensor_frame_decoder;

    import swsfd_pkg::*;

    localparam logic [1:0]  FUNC_UNUSED = 2'd3;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          DRAIN_CYCLES = 64;
    localparam int          HOLD_CYCLES = 300;
    localparam int          TOTAL_ITEMS = 750;
    localparam int          MIN_RESULTS = 48;

    typedef struct {
        logic [15:0] thr;
        logic [15:0] lo;
        logic [15:0] hi;
        logic [7:0]  tmo;
        int          budget;
        int          tx_idle;
        int          rx_idle;
    } t_setting;

    // Mirrors the decoder state and holds the frame and timeout results still owed by the block.
    class frame_scoreboard;
        t_out_item   owed_q[$];
        logic [15:0] intervals[STORE_DEPTH];
        logic [5:0]  edge_cnt;
        logic [31:0] prev_stamp;
        bit          armed;
        logic [7:0]  ticks;
        logic [15:0] thr;
        logic [15:0] win_lo;
        logic [15:0] win_hi;
        logic [7:0]  tick_limit;
        int unsigned errors;
        int unsigned n_effective;
        int unsigned n_predicted;
        int unsigned n_status[4];
        int unsigned n_late_offset;

        function new();
            thr = RST_BIT_THRESHOLD;
            win_lo = RST_RESPONSE_MIN;
            win_hi = RST_RESPONSE_MAX;
            tick_limit = RST_TIMEOUT_TICKS;
            foreach (intervals[k]) intervals[k] = '0;
            edge_cnt = '0;
            prev_stamp = '0;
            armed = 0;
            ticks = '0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] val);
            case (idx)
                CFG_BIT_THRESHOLD: thr = val;
                CFG_RESPONSE_MIN:  win_lo = val;
                CFG_RESPONSE_MAX:  win_hi = val;
                CFG_TIMEOUT_TICKS: tick_limit = val[7:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        function t_out_item decode_frame();
            t_out_item            r;
            logic [DATA_BITS-1:0] bits;
            logic [7:0]           chk;
            int                   base;
            int                   k;
            // A response interval outside the window moves the data bits one entry later.
            base = (intervals[0] >= win_lo && intervals[0] <= win_hi) ? 1 : 2;
            if (base == 2) n_late_offset++;
            for (k = 0; k < DATA_BITS; k++)
                bits[DATA_BITS-1-k] = intervals[base+k] > thr;
            r = '0;
            r.humidity_whole     = bits[39:32];
            r.humidity_tenths    = bits[31:24];
            r.temperature_whole  = bits[23:16];
            r.temperature_tenths = bits[15:8];
            r.sum_byte           = bits[7:0];
            chk = bits[39:32] + bits[31:24] + bits[23:16] + bits[15:8];
            if (chk != bits[7:0])
                r.status = STATUS_SUM;
            else if (bits[39:32] == 8'd0 && bits[23:16] == 8'd0)
                r.status = STATUS_ZERO;
            else
                r.status = STATUS_OK;
            r.edges_seen = edge_cnt;
            return r;
        endfunction

        function void note_input(t_in_item it);
            logic [31:0] diff;
            t_out_item   res;
            if (it.func == FUNC_START) begin
                foreach (intervals[k]) intervals[k] = '0;
                edge_cnt = '0;
                prev_stamp = '0;
                ticks = '0;
                armed = 1;
                n_effective++;
                return;
            end
            if (!armed || it.func == FUNC_UNUSED) return;
            n_effective++;
            if (it.func == FUNC_EDGE) begin
                diff = it.edge_stamp - prev_stamp;
                prev_stamp = it.edge_stamp;
                if (edge_cnt < STORE_DEPTH) intervals[edge_cnt] = diff[15:0];
                edge_cnt = edge_cnt + 6'd1;
                if (edge_cnt >= FRAME_EDGES) begin
                    armed = 0;
                    owed_q.push_back(decode_frame());
                    n_predicted++;
                end
            end else if (it.func == FUNC_TICK) begin
                if (ticks >= tick_limit) begin
                    armed = 0;
                    res = '0;
                    res.status = STATUS_TIMEOUT;
                    res.edges_seen = edge_cnt;
                    owed_q.push_back(res);
                    n_predicted++;
                end else begin
                    ticks = ticks + 8'd1;
                end
            end
        endfunction

        function void cmp_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (owed_q.size() == 0) begin
                errors++;
                $display("%0t: result with none expected, expected nothing, actual %p",
                         $time, got);
                return;
            end
            want = owed_q.pop_front();
            n_status[want.status]++;
            cmp_field("status", want.status, got.status);
            cmp_field("humidity_whole", want.humidity_whole, got.humidity_whole);
            cmp_field("humidity_tenths", want.humidity_tenths, got.humidity_tenths);
            cmp_field("temperature_whole", want.temperature_whole, got.temperature_whole);
            cmp_field("temperature_tenths", want.temperature_tenths, got.temperature_tenths);
            cmp_field("sum_byte", want.sum_byte, got.sum_byte);
            cmp_field("edges_seen", want.edges_seen, got.edges_seen);
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    t_in_item   in_data = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    t_out_item  out_data;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_idx = CFG_BIT_THRESHOLD;
    logic [15:0] cfg_data = '0;

    frame_scoreboard sb = new();
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int unsigned hold_seq = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;
    int unsigned stall_left = 0;
    int unsigned cycle_cnt = 0;

    single_wire_sensor_frame_decoder dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("single_wire_sensor_frame_decoder regression: fail");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready) sb.check_result(out_data);
            if (in_valid && in_ready) sb.note_input(in_data);
        end
    end

    // Result receiver: random short stalls, plus one long hold-off on request.
    always @(posedge clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= (hold_left == 1);
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_ready <= (stall_left == 1);
        end else if (rx_idle_pct != 0 && $urandom_range(1, 100) <= rx_idle_pct) begin
            stall_left <= $urandom_range(1, 14);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    task automatic offer_command(input logic [1:0] func, input logic [31:0] stamp);
        t_in_item it;
        it.func = func;
        it.edge_stamp = stamp;
        in_valid <= 1'b1;
        in_data <= it;
        do @(posedge clk); while (!in_ready);
        if (tx_idle_pct != 0 && $urandom_range(1, 100) <= tx_idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    // Drop valid, wait for every owed result, then let the decode pipeline drain.
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        sb.set_reg(idx, val);
        @(posedge clk);
    endtask

    function automatic logic [15:0] zero_interval();
        return 16'($urandom_range(0, sb.thr));
    endfunction

    function automatic logic [15:0] one_interval();
        if (sb.thr == 16'hFFFF) return 16'hFFFF;
        return 16'($urandom_range(sb.thr + 1, 16'hFFFF));
    endfunction

    function automatic logic [15:0] in_window();
        if (sb.win_lo <= sb.win_hi) return 16'($urandom_range(sb.win_lo, sb.win_hi));
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] out_window();
        if (sb.win_lo > 0 && (sb.win_hi == 16'hFFFF || $urandom_range(0, 1) == 0))
            return 16'($urandom_range(0, sb.win_lo - 1));
        if (sb.win_hi != 16'hFFFF) return 16'($urandom_range(sb.win_hi + 1, 16'hFFFF));
        return 16'($urandom);
    endfunction

    // A complete frame whose bytes aim at one of the status outcomes; some frames use random intervals instead.
    task automatic send_frame();
        logic [7:0]  bytes_v[5];
        logic [15:0] iv[FRAME_EDGES];
        logic [31:0] stamp;
        int          kind;
        int          offs;
        int          k;
        int          ticks_used;
        kind = $urandom_range(0, 9);
        for (k = 0; k < 4; k++) bytes_v[k] = 8'($urandom);
        if (kind <= 1) begin
            bytes_v[0] = 8'd0;
            bytes_v[2] = 8'd0;
        end
        bytes_v[4] = bytes_v[0] + bytes_v[1] + bytes_v[2] + bytes_v[3];
        if (kind >= 1 && kind <= 3) bytes_v[4] = bytes_v[4] ^ 8'($urandom_range(1, 255));
        offs = ($urandom_range(0, 4) == 0) ? 2 : 1;
        iv[0] = (offs == 1) ? in_window() : out_window();
        iv[1] = 16'($urandom);
        for (k = 0; k < DATA_BITS; k++) begin
            if (offs + k < FRAME_EDGES)
                iv[offs+k] = bytes_v[k/8][7 - k%8] ? one_interval() : zero_interval();
        end
        if (kind == 9) foreach (iv[j]) iv[j] = 16'($urandom);

        offer_command(FUNC_START, $urandom);
        ticks_used = 0;
        // The first interval is measured from a zero stamp, so only its low half matters.
        stamp = {16'($urandom), iv[0]};
        for (k = 0; k < FRAME_EDGES; k++) begin
            if (k != 0) begin
                stamp = stamp + iv[k];
                if ($urandom_range(0, 7) == 0) stamp = stamp + (32'($urandom_range(1, 65535)) << 16);
            end
            if (ticks_used < sb.tick_limit && $urandom_range(0, 15) == 0) begin
                offer_command(FUNC_TICK, $urandom);
                ticks_used++;
            end
            if ($urandom_range(0, 40) == 0) offer_command(FUNC_UNUSED, $urandom);
            offer_command(FUNC_EDGE, stamp);
        end
    endtask

    task automatic send_timeout_run();
        logic [31:0] stamp;
        int          n_edges;
        int          k;
        offer_command(FUNC_START, $urandom);
        n_edges = $urandom_range(0, 12);
        stamp = $urandom;
        for (k = 0; k < n_edges; k++) begin
            offer_command(FUNC_EDGE, stamp);
            stamp = stamp + $urandom_range(1, 300);
        end
        for (k = 0; k <= sb.tick_limit; k++) offer_command(FUNC_TICK, $urandom);
    endtask

    task automatic send_partial_frame();
        logic [31:0] stamp;
        int          n_edges;
        int          k;
        offer_command(FUNC_START, $urandom);
        n_edges = $urandom_range(1, FRAME_EDGES - 1);
        stamp = $urandom;
        for (k = 0; k < n_edges; k++) begin
            offer_command(FUNC_EDGE, stamp);
            stamp = stamp + $urandom_range(20, 200);
        end
    endtask

    task automatic send_noise();
        int k;
        for (k = $urandom_range(1, 4); k > 0; k--)
            offer_command(2'($urandom_range(0, 3)), $urandom);
    endtask

    task automatic random_traffic(input int budget);
        int unsigned target;
        int          pick;
        target = sb.n_effective + budget;
        while (sb.n_effective < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                send_frame();
            else if (pick < 75 && (sb.tick_limit <= 40 || $urandom_range(0, 9) == 0))
                send_timeout_run();
            else if (pick < 88)
                send_partial_frame();
            else
                send_noise();
        end
    endtask

    task automatic apply_setting(input t_setting s);
        settle();
        write_reg(CFG_BIT_THRESHOLD, s.thr);
        write_reg(CFG_RESPONSE_MIN, s.lo);
        write_reg(CFG_RESPONSE_MAX, s.hi);
        // Upper bits of the data word lie outside the 8-bit tick limit.
        write_reg(CFG_TIMEOUT_TICKS, {8'($urandom), s.tmo});
        cfg_we <= 1'b0;
        tx_idle_pct = s.tx_idle;
        rx_idle_pct <= s.rx_idle;
    endtask

    initial begin
        t_setting plan[6];
        int       p;
        int       k;
        plan[0] = '{RST_BIT_THRESHOLD, RST_RESPONSE_MIN, RST_RESPONSE_MAX, RST_TIMEOUT_TICKS,
                    60, 25, 20};
        plan[1] = '{16'd0, 16'd0, 16'hFFFF, 8'd0, 50, 10, 10};
        plan[2] = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 30, 40, 30};
        plan[3] = '{16'd90, 16'd300, 16'd100, 8'd5, 50, 0, 0};
        plan[4].thr = 16'($urandom_range(20, 2000));
        plan[4].lo = 16'($urandom_range(0, 30000));
        plan[4].hi = 16'(plan[4].lo + $urandom_range(0, 30000));
        plan[4].tmo = 8'($urandom_range(1, 60));
        plan[4].budget = 70;
        plan[4].tx_idle = 25;
        plan[4].rx_idle = 25;
        plan[5] = '{RST_BIT_THRESHOLD, RST_RESPONSE_MIN, RST_RESPONSE_MAX, RST_TIMEOUT_TICKS,
                    60, 0, 0};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        tx_idle_pct = plan[0].tx_idle;
        rx_idle_pct <= plan[0].rx_idle;
        @(posedge clk);

        // Directed: ignored commands while idle, stamp extremes, a wrapping interval, restart.
        offer_command(FUNC_EDGE, 32'hFFFF_FFFF);
        offer_command(FUNC_TICK, 32'h0000_0000);
        offer_command(FUNC_UNUSED, 32'hAAAA_AAAA);
        offer_command(FUNC_START, 32'h5555_5555);
        offer_command(FUNC_UNUSED, 32'h0000_0000);
        offer_command(FUNC_EDGE, 32'hFFFF_FFF0);
        offer_command(FUNC_EDGE, 32'h0000_0010);
        offer_command(FUNC_TICK, 32'hFFFF_FFFF);
        offer_command(FUNC_START, 32'h0000_0000);
        offer_command(FUNC_EDGE, 32'h0000_0000);
        offer_command(FUNC_EDGE, 32'h8000_0000);

        for (p = 0; p < 6; p++) begin
            if (p != 0) apply_setting(plan[p]);
            if (p == 1) begin
                // Timeouts come back to back while the receiver holds off.
                hold_seq <= hold_seq + 1;
                for (k = 0; k < 8; k++) send_timeout_run();
            end
            if (p == 2) send_timeout_run();
            random_traffic(plan[p].budget);
        end
        while (sb.n_effective < TOTAL_ITEMS || sb.n_predicted < MIN_RESULTS) send_frame();
        settle();

        $display("Covered %0d transactions under 6 register settings, %0d with late data offset.",
                 sb.n_effective, sb.n_late_offset);
        $display("Results: %0d ok, %0d checksum, %0d zero reading, %0d timeout.",
                 sb.n_status[STATUS_OK], sb.n_status[STATUS_SUM], sb.n_status[STATUS_ZERO],
                 sb.n_status[STATUS_TIMEOUT]);
        if (sb.errors == 0)
            $display("single_wire_sensor_frame_decoder regression: pass");
        else
            $display("single_wire_sensor_frame_decoder regression: fail");
        $finish;
    end

endmodule

### single_wire_sensor_frame_decoder.f
+incdir+rtl/core
rtl/core/swsfd_pkg.sv
rtl/core/swsfd_interval_ram.sv
rtl/core/swsfd_bit_decoder.sv
rtl/core/single_wire_sensor_frame_decoder.sv
sim/tb_single_wire_sensor_frame_decoder.sv
